>>> sv/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the motor speed command sequencer
// Holds the configuration record, the unpacked pass record, the frame command
// that travels from the sequencer to the serializer, and the frame layout.
// ----------------------------------------------------------------------------
package msc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_MAX_SPEED  = 3'd0;
    localparam logic [2:0] CFG_MIN_SPEED  = 3'd1;
    localparam logic [2:0] CFG_HYSTERESIS = 3'd2;
    localparam logic [2:0] CFG_DIRECTION  = 3'd3;
    localparam logic [2:0] CFG_POLL       = 3'd4;
    localparam logic [2:0] CFG_RESUME     = 3'd5;
    localparam logic [2:0] CFG_RESUME_FLT = 3'd6;

    // register values after reset
    localparam logic [15:0] MAX_SPEED_RESET  = 16'd1800;
    localparam logic [15:0] MIN_SPEED_RESET  = 16'd300;
    localparam logic [15:0] HYSTERESIS_RESET = 16'd0;
    localparam logic        DIRECTION_RESET  = 1'b0;
    localparam logic [15:0] POLL_RESET       = 16'd100;
    localparam logic [15:0] RESUME_RESET     = 16'd1000;
    localparam logic [15:0] RESUME_FLT_RESET = 16'd5000;

    // stop monitor margin above minimum speed
    localparam logic [16:0] STOP_MARGIN_RPM = 17'd10;

    // demand scaling: floor(p / 10000) as (p * RECIP) >> RECIP_SHIFT, exact for p < 2^30
    localparam longint unsigned DEMAND_SCALE = 64'd10000;
    localparam int PROD1_BITS  = 30;
    localparam int RECIP_BITS  = 31;
    localparam int PROD2_BITS  = PROD1_BITS + RECIP_BITS;
    localparam int RECIP_SHIFT = 44;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + DEMAND_SCALE - 64'd1) / DEMAND_SCALE;

    // frame layout
    localparam int          FRAME_LEN  = 10;
    localparam int          IDX_BITS   = 4;
    localparam logic [7:0]  FRM_SYNC   = 8'h55;
    localparam logic [7:0]  FRM_ADDR   = 8'h03;
    localparam logic [7:0]  FRM_CMD    = 8'h21;
    localparam logic [7:0]  FRM_ZERO   = 8'h00;
    localparam logic [7:0]  FRM_TAIL   = 8'hCC;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAME_LEN - 1);

    // queue between sequencer and serializer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] max_speed_rpm;
        logic [15:0] min_speed_rpm;
        logic [15:0] hysteresis_rpm;
        logic        configured_direction;
        logic [15:0] poll_period;
        logic [15:0] resume_period;
        logic [15:0] resume_period_fault;
    } cfg_t;

    typedef struct packed {
        logic        invert_direction;
        logic [15:0] drive_status;
        logic [15:0] measured_speed;
        logic [13:0] demand_percent;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [15:0] speed;
        logic        direction;
        logic        motor_on;
        logic [15:0] reference_speed;
    } frame_cmd_t;

    // one byte of the speed frame at position idx
    function automatic logic [7:0] frame_byte_f(frame_cmd_t cmd, logic [IDX_BITS-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0: b = FRM_SYNC;
            4'd1: b = FRM_ADDR;
            4'd2: b = FRM_CMD;
            4'd3: b = FRM_ZERO;
            4'd4: b = FRM_ZERO;
            4'd5: b = cmd.speed[15:8];
            4'd6: b = cmd.speed[7:0];
            4'd7: b = {7'd0, cmd.direction};
            4'd8: b = FRM_TAIL;
            4'd9: b = FRM_TAIL;
            default: b = FRM_ZERO;
        endcase
        return b;
    endfunction

endpackage

>>> sv/msc_front.sv
// ----------------------------------------------------------------------------
// msc_front: sequencer step per scheduler pass
// Takes one pass, advances the sequencer one step and hands any speed frame
// to the queue as a command. A poll that is due goes through the multiply and
// divide states to scale the demand into a speed reference.
// ----------------------------------------------------------------------------
module msc_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  msc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  msc_pkg::in_item_t   in_item,
    output logic                in_ready,
    input  logic                q_full,
    output logic                push,
    output msc_pkg::frame_cmd_t push_cmd
);
    import msc_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV} front_state_t;
    typedef enum logic [2:0] {
        PH_POLL, PH_START, PH_SPEED, PH_SLOW, PH_STOPMON, PH_RESUME, PH_RESET
    } phase_t;

    front_state_t           fstate_reg, fstate_next;
    phase_t                 phase_reg, phase_next;
    logic                   running_reg, running_next;
    logic                   dir_reg, dir_next;
    logic [15:0]            ref_reg, ref_next;
    logic [15:0]            fault_reg, fault_next;
    logic [TIME_BITS-1:0]   poll_dl_reg, poll_dl_next;
    logic [TIME_BITS-1:0]   resume_dl_reg, resume_dl_next;
    logic [PROD1_BITS-1:0]  prod1_reg, prod1_next;
    logic [PROD2_BITS-1:0]  prod2_reg, prod2_next;

    logic                   accept;
    logic [63:0]            now_wide, pp_wide, rp_wide, rpf_wide, poll_rst_wide;
    logic [TIME_BITS-1:0]   now_t, pp_t, rp_t, rpf_t, poll_rst_t;
    logic [16:0]            quo;
    logic [15:0]            ref_new;
    logic signed [17:0]     meas_ext, stop_lim, ref_ext, stop_thr;

    // wrap-safe deadline test
    function automatic logic reached(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] dl);
        logic [TIME_BITS-1:0] diff;
        diff = now - dl;
        return ~diff[TIME_BITS-1];
    endfunction

    // times and periods at the time width
    assign now_wide      = {32'd0, in_item.now_time};
    assign pp_wide       = {48'd0, cfg.poll_period};
    assign rp_wide       = {48'd0, cfg.resume_period};
    assign rpf_wide      = {48'd0, cfg.resume_period_fault};
    assign poll_rst_wide = {48'd0, POLL_RESET};
    assign now_t         = now_wide[TIME_BITS-1:0];
    assign pp_t          = pp_wide[TIME_BITS-1:0];
    assign rp_t          = rp_wide[TIME_BITS-1:0];
    assign rpf_t         = rpf_wide[TIME_BITS-1:0];
    assign poll_rst_t    = poll_rst_wide[TIME_BITS-1:0];

    // scaled reference with saturation
    assign quo     = prod2_reg[RECIP_SHIFT +: 17];
    assign ref_new = quo[16] ? 16'hFFFF : quo[15:0];

    // signed thresholds
    assign meas_ext = {{2{in_item.measured_speed[15]}}, in_item.measured_speed};
    assign stop_lim = signed'({1'b0, 17'(cfg.min_speed_rpm) + STOP_MARGIN_RPM});
    assign ref_ext  = signed'({2'b00, ref_new});
    assign stop_thr = signed'({2'b00, cfg.min_speed_rpm}) - signed'({2'b00, cfg.hysteresis_rpm});

    assign in_ready = (fstate_reg == F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;

    // sequencer step
    always_comb begin
        fstate_next    = fstate_reg;
        phase_next     = phase_reg;
        running_next   = running_reg;
        dir_next       = dir_reg;
        ref_next       = ref_reg;
        fault_next     = fault_reg;
        poll_dl_next   = poll_dl_reg;
        resume_dl_next = resume_dl_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        push           = 1'b0;
        push_cmd.speed           = ref_reg;
        push_cmd.direction       = dir_reg;
        push_cmd.motor_on        = running_reg;
        push_cmd.reference_speed = ref_reg;

        unique case (fstate_reg)
            F_IDLE: begin
                if (accept) begin
                    unique case (phase_reg)
                        PH_START: begin
                            dir_next     = cfg.configured_direction ^ in_item.invert_direction;
                            running_next = 1'b1;
                            poll_dl_next = now_t + pp_t;
                            phase_next   = PH_POLL;
                        end
                        PH_SPEED: begin
                            push         = running_reg;
                            poll_dl_next = now_t + pp_t;
                            phase_next   = PH_POLL;
                        end
                        PH_SLOW: begin
                            push           = running_reg;
                            push_cmd.speed = cfg.min_speed_rpm;
                            phase_next     = PH_STOPMON;
                        end
                        PH_STOPMON: begin
                            push_cmd.speed = 16'd0;
                            if (!running_reg || fault_reg != 16'd0) begin
                                push           = 1'b1;
                                resume_dl_next = now_t + rpf_t;
                                phase_next     = PH_RESUME;
                            end else if (meas_ext <= stop_lim) begin
                                push           = 1'b1;
                                resume_dl_next = now_t + rp_t;
                                phase_next     = PH_RESUME;
                            end else if (ref_reg >= cfg.min_speed_rpm) begin
                                phase_next = PH_SPEED;
                            end
                        end
                        PH_RESUME: begin
                            if (reached(now_t, resume_dl_reg)) begin
                                resume_dl_next = '0;
                                running_next   = 1'b0;
                                phase_next     = PH_RESET;
                            end
                        end
                        PH_RESET: begin
                            if (ref_reg < cfg.min_speed_rpm) begin
                                phase_next = PH_POLL;
                            end
                        end
                        default: begin
                            // poll, and the unused code
                            phase_next = PH_POLL;
                            if (reached(now_t, poll_dl_reg)) begin
                                prod1_next  = PROD1_BITS'(in_item.demand_percent)
                                            * PROD1_BITS'(cfg.max_speed_rpm);
                                fault_next  = in_item.drive_status;
                                fstate_next = F_MUL;
                            end
                        end
                    endcase
                end
            end
            F_MUL: begin
                prod2_next  = PROD2_BITS'(prod1_reg) * PROD2_BITS'(RECIP_BITS'(RECIP));
                fstate_next = F_DIV;
            end
            F_DIV: begin
                ref_next    = ref_new;
                fstate_next = F_IDLE;
                if (!running_reg) begin
                    phase_next = (ref_new >= cfg.min_speed_rpm) ? PH_START : PH_SPEED;
                end else begin
                    phase_next = (ref_ext < stop_thr) ? PH_SLOW : PH_SPEED;
                end
            end
            default: begin
                fstate_next = F_IDLE;
            end
        endcase
    end

    // state and registered values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg    <= F_IDLE;
            phase_reg     <= PH_POLL;
            running_reg   <= 1'b0;
            dir_reg       <= DIRECTION_RESET;
            ref_reg       <= 16'd0;
            fault_reg     <= 16'd0;
            poll_dl_reg   <= poll_rst_t;
            resume_dl_reg <= '0;
        end else begin
            fstate_reg    <= fstate_next;
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            dir_reg       <= dir_next;
            ref_reg       <= ref_next;
            fault_reg     <= fault_next;
            poll_dl_reg   <= poll_dl_next;
            resume_dl_reg <= resume_dl_next;
        end
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
    end

    // scaling always runs multiply then reference update
    a_mul_then_div: assert property (@(posedge aclk) disable iff (!aresetn)
        fstate_reg == F_MUL |=> fstate_reg == F_DIV)
        else $error("scaling sequence broken");

    // no pass taken while the reference is being scaled
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        fstate_reg != F_IDLE |-> !in_ready)
        else $error("pass accepted during scaling");

    // a frame command only comes from an accepted pass with queue room
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (accept && !q_full))
        else $error("frame command without an accepted pass");

    // resume wait is left only with the motor marked stopped
    a_resume_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RESET) |-> !running_reg)
        else $error("reset wait with motor running");

endmodule

>>> sv/msc_queue.sv
// ----------------------------------------------------------------------------
// msc_queue: short command queue
// Holds frame commands between the sequencer and the serializer so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
module msc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  msc_pkg::frame_cmd_t push_cmd,
    input  logic                pop,
    output msc_pkg::frame_cmd_t head_cmd,
    output logic                empty,
    output logic                full
);
    import msc_pkg::*;

    frame_cmd_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_cmd = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("frame command pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

>>> sv/msc_serializer.sv
// ----------------------------------------------------------------------------
// msc_serializer: frame byte serializer
// Takes frame commands from the queue and sends each as ten bytes, one per
// output request, the tenth marked last.
// ----------------------------------------------------------------------------
module msc_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  msc_pkg::frame_cmd_t head_cmd,
    input  logic                q_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tlast
);
    import msc_pkg::*;

    logic                   active_reg, active_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    frame_cmd_t             cmd_reg, cmd_next;
    logic                   at_last, free;

    assign at_last = (idx_reg == LAST_IDX);
    assign free    = !active_reg || (m_tready && at_last);
    assign pop     = free && !q_empty;

    // byte counter and command hold
    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        if (pop) begin
            active_next = 1'b1;
            idx_next    = '0;
            cmd_next    = head_cmd;
        end else if (free) begin
            active_next = 1'b0;
        end else if (m_tready) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
        cmd_reg <= cmd_next;
    end

    // output byte with its running flag and reference
    assign m_tvalid = active_reg;
    assign m_tlast  = active_reg && at_last;
    assign m_tdata  = {7'd0, cmd_reg.reference_speed, cmd_reg.motor_on,
                       frame_byte_f(cmd_reg, idx_reg)};

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (idx_reg <= LAST_IDX))
        else $error("byte index past end of frame");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && m_tready && !at_last) |=> (active_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("byte index did not advance");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !m_tready) |=> (active_reg && $stable(idx_reg)))
        else $error("byte index moved during stall");

endmodule

>>> sv/motor_speed_command_sequencer.sv
// ----------------------------------------------------------------------------
// motor_speed_command_sequencer: speed command sequencer for a motor drive
// Runs one sequencer step per scheduler pass and sends speed command frames
// as a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one scheduler pass per request (time, demand, measured speed,
//   drive status, invert input). m_ channel: frame bytes, ten per frame,
//   the tenth with m_tlast high; each byte also carries the running flag and
//   the latched speed reference.
//   A pass that polls at its deadline goes through the multiply and divide
//   states, the demand scaling using two multiplier stages. A pass that makes
//   a frame puts it in a two-entry queue; its first byte shows once the queue
//   holds it and the serializer has loaded it. Frames go out back to back, and
//   passes without frames are taken one per cycle while no poll is scaled.
//   s_tready drops while a poll is being scaled and while the queue is full;
//   a stall on m_tready holds the current byte and fills the queue.
//   After reset the registers hold their defaults, the sequencer waits in
//   poll with the motor stopped and the first poll due at tick 100.
//   The user writes registers via cfg_we, cfg_index and cfg_wdata only while
//   the block is idle (not enforced); indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module motor_speed_command_sequencer #(
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // pass requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // now_time[31:0], demand_percent[45:32],
                                   // measured_speed[61:46], drive_status[77:62],
                                   // invert_direction[78]
    // frame bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame_byte[7:0], motor_on[8], reference_speed[24:9]
    output logic        m_tlast
);
    import msc_pkg::*;

    cfg_t       cfg_reg;
    in_item_t   in_item;
    logic       q_full, q_empty, push, pop;
    frame_cmd_t push_cmd, head_cmd;

    assign in_item = in_item_t'(s_tdata[78:0]);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed_rpm        <= MAX_SPEED_RESET;
            cfg_reg.min_speed_rpm        <= MIN_SPEED_RESET;
            cfg_reg.hysteresis_rpm       <= HYSTERESIS_RESET;
            cfg_reg.configured_direction <= DIRECTION_RESET;
            cfg_reg.poll_period          <= POLL_RESET;
            cfg_reg.resume_period        <= RESUME_RESET;
            cfg_reg.resume_period_fault  <= RESUME_FLT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_SPEED:  cfg_reg.max_speed_rpm        <= cfg_wdata;
                CFG_MIN_SPEED:  cfg_reg.min_speed_rpm        <= cfg_wdata;
                CFG_HYSTERESIS: cfg_reg.hysteresis_rpm       <= cfg_wdata;
                CFG_DIRECTION:  cfg_reg.configured_direction <= cfg_wdata[0];
                CFG_POLL:       cfg_reg.poll_period          <= cfg_wdata;
                CFG_RESUME:     cfg_reg.resume_period        <= cfg_wdata;
                CFG_RESUME_FLT: cfg_reg.resume_period_fault  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    msc_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .in_ready (s_tready),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    msc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    msc_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
